[sv/mop_pkg.sv]
package mop_pkg;

	typedef struct packed {
		logic [10:0] pixel_x;
		logic [9:0]  pixel_y;
	} in_t;

	typedef struct packed {
		logic [7:0] palette_index;
		logic       inside_set;
		logic [9:0] iteration_count;
	} out_t;

	typedef struct packed {
		logic signed [47:0] center_re;
		logic signed [47:0] center_im;
		logic [46:0]        pixel_step;
		logic signed [31:0] cos_rot;
		logic signed [31:0] sin_rot;
		logic [9:0]         max_iters;
		logic [3:0]         band;
		logic [7:0]         base_index;
	} cfg_t;

	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_RE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_IM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COS_ROT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIN_ROT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BAND       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_INDEX = 3'd7;

	// Datapath operations, one per controller step.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_MU,
		OP_MV,
		OP_R1,
		OP_R2,
		OP_R3,
		OP_R4,
		OP_C,
		OP_ZI,
		OP_SQR,
		OP_SQI,
		OP_TRAP,
		OP_L1,
		OP_L2,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MU,
		ST_MV,
		ST_R1,
		ST_R2,
		ST_R3,
		ST_R4,
		ST_C,
		ST_CHK,
		ST_ZI,
		ST_SQR,
		ST_SQI,
		ST_TRAP,
		ST_L1,
		ST_L2,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic log_done;
		logic loop_go;
		logic limit_hit;
	} sts_t;

	localparam logic [15:0] LN2_Q16 = 16'd45426;
	localparam logic [5:0]  FB_TRAP = 6'd44;
	localparam logic [5:0]  FB_L1   = 6'd28;
	localparam logic [5:0]  FB_L2   = 6'd16;
	localparam logic [63:0] EPS_LSB = 64'd18;

	// log2(1 + k/16) in Q.16
	function automatic logic [16:0] log2_tab(input logic [4:0] k);
		logic [16:0] v;
		case (k)
			5'd0:    v = 17'd0;
			5'd1:    v = 17'd5732;
			5'd2:    v = 17'd11136;
			5'd3:    v = 17'd16248;
			5'd4:    v = 17'd21098;
			5'd5:    v = 17'd25711;
			5'd6:    v = 17'd30109;
			5'd7:    v = 17'd34312;
			5'd8:    v = 17'd38336;
			5'd9:    v = 17'd42196;
			5'd10:   v = 17'd45904;
			5'd11:   v = 17'd49472;
			5'd12:   v = 17'd52911;
			5'd13:   v = 17'd56228;
			5'd14:   v = 17'd59434;
			5'd15:   v = 17'd62534;
			5'd16:   v = 17'd65536;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

[sv/mop_mul.sv]
module mop_mul
	import mop_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] product
);

	logic [2:0]   cnt_q;
	logic [63:0]  p_s1;
	logic [1:0]   sh_s1;
	logic [127:0] acc_q;
	logic [31:0]  a_part;
	logic [31:0]  b_part;
	logic [127:0] p_shift;

	assign a_part = cnt_q[0] ? a[63:32] : a[31:0];
	assign b_part = cnt_q[1] ? b[63:32] : b[31:0];

	always_comb begin
		case (sh_s1)
			2'd0:    p_shift = {64'd0, p_s1};
			2'd1:    p_shift = {32'd0, p_s1, 32'd0};
			default: p_shift = {p_s1, 64'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (!go || cnt_q == 3'd5) begin
			cnt_q <= 3'd0;
		end else begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	// One 32x32 partial product per cycle, registered and accumulated in the next cycle.
	always_ff @(posedge clk) begin
		if (go && cnt_q < 3'd4) begin
			p_s1  <= a_part * b_part;
			sh_s1 <= 2'({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]});
		end
		if (go && cnt_q == 3'd1) begin
			acc_q <= p_shift;
		end else if (go && cnt_q > 3'd1 && cnt_q < 3'd5) begin
			acc_q <= acc_q + p_shift;
		end
	end

	assign done    = go && cnt_q == 3'd5;
	assign product = acc_q;

endmodule

[sv/mop_log.sv]
module mop_log
	import mop_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] x,
	output logic        done,
	output logic [5:0]  expo,
	output logic [16:0] frac
);

	logic [3:0]  cnt_q;
	logic [63:0] n_q;
	logic [5:0]  e_q;
	logic [16:0] frac_q;
	logic [3:0]  k;
	logic [15:0] r;
	logic [12:0] d;
	logic [28:0] dr;

	assign k  = n_q[62:59];
	assign r  = n_q[58:43];
	assign d  = 13'(log2_tab({1'b0, k} + 5'd1) - log2_tab({1'b0, k}));
	assign dr = d * r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else if (!go || cnt_q == 4'd8) begin
			cnt_q <= 4'd0;
		end else begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	// Leading-one search in six halving steps, then table interpolation.
	always_ff @(posedge clk) begin
		if (go) begin
			case (cnt_q)
				4'd0: begin
					n_q <= (x == 64'd0) ? 64'd1 : x;
					e_q <= 6'd63;
				end
				4'd1: if (n_q[63:32] == 32'd0) begin
					n_q <= n_q << 32;
					e_q <= e_q - 6'd32;
				end
				4'd2: if (n_q[63:48] == 16'd0) begin
					n_q <= n_q << 16;
					e_q <= e_q - 6'd16;
				end
				4'd3: if (n_q[63:56] == 8'd0) begin
					n_q <= n_q << 8;
					e_q <= e_q - 6'd8;
				end
				4'd4: if (n_q[63:60] == 4'd0) begin
					n_q <= n_q << 4;
					e_q <= e_q - 6'd4;
				end
				4'd5: if (n_q[63:62] == 2'd0) begin
					n_q <= n_q << 2;
					e_q <= e_q - 6'd2;
				end
				4'd6: if (!n_q[63]) begin
					n_q <= n_q << 1;
					e_q <= e_q - 6'd1;
				end
				4'd7: frac_q <= log2_tab({1'b0, k}) + 17'(dr[28:16]);
				default: ;
			endcase
		end
	end

	assign done = go && cnt_q == 4'd8;
	assign expo = e_q;
	assign frac = frac_q;

endmodule

[sv/mop_dp.sv]
module mop_dp
	import mop_pkg::*;
#(
	parameter int FRAME_WIDTH  = 1280,
	parameter int FRAME_HEIGHT = 960
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  cfg_t cfg,
	input  in_t  pixel,
	output sts_t sts,
	output logic done,
	output out_t result
);

	localparam logic signed [13:0] W_S = 14'(FRAME_WIDTH);
	localparam logic signed [13:0] H_S = 14'(FRAME_HEIGHT);

	function automatic logic [63:0] mag64(input logic signed [63:0] a);
		return a[63] ? 64'(-a) : 64'(a);
	endfunction

	function automatic logic signed [63:0] sat_neg(input logic [127:0] s, input logic neg);
		logic [63:0] r;
		r = (s[127:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : s[63:0];
		return neg ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [65:0] s);
		logic signed [47:0] r;
		if (s > 66'sd140737488355327) begin
			r = 48'sh7FFF_FFFF_FFFF;
		end else if (s < -66'sd140737488355328) begin
			r = 48'sh8000_0000_0000;
		end else begin
			r = s[47:0];
		end
		return r;
	endfunction

	function automatic logic signed [47:0] down16(input logic signed [47:0] v);
		return (v + (v[47] ? 48'sd65535 : 48'sd0)) >>> 16;
	endfunction

	function automatic logic signed [23:0] lg(input logic [5:0] e, input logic [5:0] fb,
			input logic [16:0] f);
		logic signed [6:0] dd;
		dd = $signed({1'b0, e}) - $signed({1'b0, fb});
		return 24'($signed({dd, 16'h0})) + 24'(f);
	endfunction

	logic [10:0]        x_q;
	logic [9:0]         y_q;
	logic signed [63:0] u_q, v_q, m1_q, m2_q, m3_q, m4_q;
	logic signed [47:0] cr_q, ci_q;
	logic signed [63:0] zr_q, zi_q;
	logic [63:0]        sr_q, si_q, trap_q, l1_q;
	logic [83:0]        sq1_q;
	logic [84:0]        sum_q;
	logic               esc_q;
	logic [9:0]         i_q;
	logic signed [24:0] t_q;
	logic signed [27:0] nu_q;
	logic               done_q;
	out_t               res_q;

	logic signed [13:0] dx, dy;
	logic [63:0]        ar, ai, mn, cs_m, sn_m, tp;
	logic [64:0]        tp_sum;
	logic               mul_go, log_go, mul_done, log_done;
	logic [63:0]        mul_a, mul_b, log_x;
	logic [127:0]       prod;
	logic [5:0]         log_e;
	logic [16:0]        log_f;
	logic [5:0]         log_fb;
	logic signed [23:0] lv;
	logic signed [40:0] tprod;
	logic [83:0]        sq2;
	logic [84:0]        sum_n;
	logic signed [65:0] s_r, s_i;
	logic signed [9:0]  kin;
	logic signed [34:0] p_in, p_t13;
	logic signed [32:0] p_nu;
	logic [7:0]         idx;

	assign dx   = $signed({2'b00, x_q, 1'b0}) - W_S;
	assign dy   = $signed({3'b000, y_q, 1'b0}) - H_S;
	assign ar   = mag64(zr_q);
	assign ai   = mag64(zi_q);
	assign mn   = (ar < ai) ? ar : ai;
	assign cs_m = mag64(64'(cfg.cos_rot));
	assign sn_m = mag64(64'(cfg.sin_rot));

	assign tp_sum = {1'b0, trap_q} + {1'b0, EPS_LSB};
	assign tp     = tp_sum[64] ? '1 : tp_sum[63:0];

	always_comb begin
		mul_go = 1'b0;
		log_go = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		log_x  = '0;
		log_fb = FB_TRAP;
		unique case (cmd.op)
			OP_MU: begin
				mul_go = 1'b1;
				mul_a  = mag64(64'(dx));
				mul_b  = 64'(cfg.pixel_step);
			end
			OP_MV: begin
				mul_go = 1'b1;
				mul_a  = mag64(64'(dy));
				mul_b  = 64'(cfg.pixel_step);
			end
			OP_R1: begin
				mul_go = 1'b1;
				mul_a  = mag64(u_q);
				mul_b  = cs_m;
			end
			OP_R2: begin
				mul_go = 1'b1;
				mul_a  = mag64(v_q);
				mul_b  = sn_m;
			end
			OP_R3: begin
				mul_go = 1'b1;
				mul_a  = mag64(u_q);
				mul_b  = sn_m;
			end
			OP_R4: begin
				mul_go = 1'b1;
				mul_a  = mag64(v_q);
				mul_b  = cs_m;
			end
			OP_ZI: begin
				mul_go = 1'b1;
				mul_a  = ar;
				mul_b  = ai;
			end
			OP_SQR: begin
				mul_go = 1'b1;
				mul_a  = ar;
				mul_b  = ar;
			end
			OP_SQI: begin
				mul_go = 1'b1;
				mul_a  = ai;
				mul_b  = ai;
			end
			OP_TRAP: begin
				log_go = 1'b1;
				log_x  = tp;
				log_fb = FB_TRAP;
			end
			OP_L1: begin
				log_go = 1'b1;
				log_x  = sum_q[79:16];
				log_fb = FB_L1;
			end
			OP_L2: begin
				log_go = 1'b1;
				log_x  = l1_q;
				log_fb = FB_L2;
			end
			default: ;
		endcase
	end

	mop_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (mul_go),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (prod)
	);

	mop_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (log_go),
		.x      (log_x),
		.done   (log_done),
		.expo   (log_e),
		.frac   (log_f)
	);

	assign lv    = lg(log_e, log_fb, log_f);
	assign tprod = 41'(lv) * $signed({25'd0, LN2_Q16});
	assign sq2   = prod[127:44];
	assign sum_n = {1'b0, sq1_q} + {1'b0, sq2};
	assign s_r   = 66'(cfg.center_re) + 66'(m1_q) - 66'(m2_q);
	assign s_i   = 66'(cfg.center_im) + 66'(m3_q) + 66'(m4_q);

	assign kin   = -$signed({2'b00, cfg.band, 4'h0});
	assign p_in  = 35'(t_q) * 35'(kin);
	assign p_t13 = 35'(t_q) * -35'sd13;
	assign p_nu  = 33'(nu_q) * $signed({29'd0, cfg.band});

	always_comb begin
		if (sts.limit_hit) begin
			idx = cfg.base_index + 8'd128 + 8'(down16(48'(p_in)));
		end else begin
			idx = cfg.base_index + 8'(down16(48'(p_nu))) + 8'(down16(48'(p_t13)));
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				x_q <= pixel.pixel_x;
				y_q <= pixel.pixel_y;
			end
			OP_MU: if (mul_done) u_q <= dx[13] ? -$signed(prod[64:1]) : $signed(prod[64:1]);
			OP_MV: if (mul_done) v_q <= dy[13] ? -$signed(prod[64:1]) : $signed(prod[64:1]);
			OP_R1: if (mul_done) m1_q <= sat_neg({30'd0, prod[127:30]}, u_q[63] ^ cfg.cos_rot[31]);
			OP_R2: if (mul_done) m2_q <= sat_neg({30'd0, prod[127:30]}, v_q[63] ^ cfg.sin_rot[31]);
			OP_R3: if (mul_done) m3_q <= sat_neg({30'd0, prod[127:30]}, u_q[63] ^ cfg.sin_rot[31]);
			OP_R4: if (mul_done) m4_q <= sat_neg({30'd0, prod[127:30]}, v_q[63] ^ cfg.cos_rot[31]);
			OP_C: begin
				cr_q   <= sat48(s_r);
				ci_q   <= sat48(s_i);
				zr_q   <= '0;
				zi_q   <= '0;
				sr_q   <= '0;
				si_q   <= '0;
				sum_q  <= '0;
				trap_q <= '1;
				esc_q  <= 1'b0;
				i_q    <= '0;
			end
			OP_ZI: if (mul_done) begin
				zi_q <= sat_neg({43'd0, prod[127:43]}, zr_q[63] ^ zi_q[63]) + 64'(ci_q);
				zr_q <= $signed(sr_q - si_q) + 64'(cr_q);
			end
			OP_SQR: if (mul_done) sq1_q <= prod[127:44];
			OP_SQI: if (mul_done) begin
				sum_q <= sum_n;
				esc_q <= sum_n > (85'd1 << 60);
				sr_q  <= sq1_q[63:0];
				si_q  <= sq2[63:0];
				if (mn < trap_q) begin
					trap_q <= mn;
				end
				i_q <= i_q + 10'd1;
			end
			OP_TRAP: if (log_done) t_q <= 25'(down16(48'(tprod)));
			OP_L1: if (log_done) l1_q <= 64'(lv);
			OP_L2: if (log_done) begin
				nu_q <= $signed({1'b0, 11'({1'b0, i_q} + 11'd2), 16'h0}) - 28'(lv);
			end
			OP_OUT: begin
				res_q.palette_index   <= idx;
				res_q.inside_set      <= sts.limit_hit;
				res_q.iteration_count <= i_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.op == OP_OUT);
		end
	end

	assign sts.mul_done  = mul_done;
	assign sts.log_done  = log_done;
	assign sts.loop_go   = (i_q < cfg.max_iters) && !esc_q;
	assign sts.limit_hit = (i_q >= cfg.max_iters);
	assign done          = done_q;
	assign result        = res_q;

endmodule

[sv/mop_ctrl.sv]
module mop_ctrl
	import mop_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_n = ST_MU;
			ST_MU:   if (sts.mul_done) state_n = ST_MV;
			ST_MV:   if (sts.mul_done) state_n = ST_R1;
			ST_R1:   if (sts.mul_done) state_n = ST_R2;
			ST_R2:   if (sts.mul_done) state_n = ST_R3;
			ST_R3:   if (sts.mul_done) state_n = ST_R4;
			ST_R4:   if (sts.mul_done) state_n = ST_C;
			ST_C:    state_n = ST_CHK;
			ST_CHK:  state_n = sts.loop_go ? ST_ZI : ST_TRAP;
			ST_ZI:   if (sts.mul_done) state_n = ST_SQR;
			ST_SQR:  if (sts.mul_done) state_n = ST_SQI;
			ST_SQI:  if (sts.mul_done) state_n = ST_CHK;
			ST_TRAP: if (sts.log_done) state_n = sts.limit_hit ? ST_OUT : ST_L1;
			ST_L1:   if (sts.log_done) state_n = ST_L2;
			ST_L2:   if (sts.log_done) state_n = ST_OUT;
			ST_OUT:  state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		busy   = 1'b1;
		cmd.op = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				cmd.op = start ? OP_LOAD : OP_NONE;
			end
			ST_MU:   cmd.op = OP_MU;
			ST_MV:   cmd.op = OP_MV;
			ST_R1:   cmd.op = OP_R1;
			ST_R2:   cmd.op = OP_R2;
			ST_R3:   cmd.op = OP_R3;
			ST_R4:   cmd.op = OP_R4;
			ST_C:    cmd.op = OP_C;
			ST_CHK:  cmd.op = OP_NONE;
			ST_ZI:   cmd.op = OP_ZI;
			ST_SQR:  cmd.op = OP_SQR;
			ST_SQI:  cmd.op = OP_SQI;
			ST_TRAP: cmd.op = OP_TRAP;
			ST_L1:   cmd.op = OP_L1;
			ST_L2:   cmd.op = OP_L2;
			ST_OUT:  cmd.op = OP_OUT;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

[sv/mandelbrot_orbit_trap_pixel.sv]
// Channel   Ports                                  Transfer when
// pixel     start, busy, pixel                     start && !busy
// result    done, result                           done (one cycle, no stall)
// config    cfg_wr_en, cfg_index, cfg_wdata        cfg_wr_en
//
// Each iteration runs the ZI, SQR and SQI products and a check; a pixel that
// escapes also takes the log steps L1 and L2 before its result strobe.
// Every 64x64 product goes through one shared 32x32 multiplier as four partial
// products; logs go through the normalizing unit.
// Reset clears the configuration to its defaults and returns to idle.
// The receiver cannot stall; busy stays high until the result state is left.
module mandelbrot_orbit_trap_pixel
	import mop_pkg::*;
#(
	parameter int FRAME_WIDTH  = 1280,
	parameter int FRAME_HEIGHT = 960
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_t                   pixel,
	output logic                  done,
	output out_t                  result,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_re  <= '0;
			cfg_q.center_im  <= '0;
			cfg_q.pixel_step <= '0;
			cfg_q.cos_rot    <= 32'sd1073741824;
			cfg_q.sin_rot    <= '0;
			cfg_q.max_iters  <= 10'd700;
			cfg_q.band       <= 4'd3;
			cfg_q.base_index <= 8'd8;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CENTER_RE:  cfg_q.center_re  <= cfg_wdata[47:0];
				REG_CENTER_IM:  cfg_q.center_im  <= cfg_wdata[47:0];
				REG_PIXEL_STEP: cfg_q.pixel_step <= cfg_wdata[46:0];
				REG_COS_ROT:    cfg_q.cos_rot    <= cfg_wdata[31:0];
				REG_SIN_ROT:    cfg_q.sin_rot    <= cfg_wdata[31:0];
				REG_MAX_ITERS:  cfg_q.max_iters  <= cfg_wdata[9:0];
				REG_BAND:       cfg_q.band       <= cfg_wdata[3:0];
				REG_BASE_INDEX: cfg_q.base_index <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	mop_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	mop_dp #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.pixel  (pixel),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule
